// ----- hdl/assert_macros.svh -----
// assertion helpers for the checker file tcbp_checker.sv
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, held off during reset
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("implication check failed");

// next-cycle implication, held off during reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

// ----- hdl/tcbp_pkg.sv -----
// ----------------------------------------------------------------------------
// tcbp_pkg
// Types and constants for the three-cell battery protection check pipeline.
// ----------------------------------------------------------------------------
package tcbp_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 18;

  localparam logic [CFG_IDX_W-1:0] REG_PACK_MAX       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PACK_MIN       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CELL_MAX       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CELL_MIN       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_IMBALANCE      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_UPPER_SAFE     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_DISCHARGE_LIM  = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_CHARGE_LIM     = 3'd7;

  localparam logic [17:0] RST_PACK_MAX      = 18'd7400;
  localparam logic [17:0] RST_PACK_MIN      = 18'd1000;
  localparam logic [15:0] RST_CELL_MAX      = 16'd2600;
  localparam logic [15:0] RST_CELL_MIN      = 16'd1000;
  localparam logic [15:0] RST_IMBALANCE     = 16'd300;
  localparam logic [15:0] RST_UPPER_SAFE    = 16'd2450;
  localparam logic [15:0] RST_DISCHARGE_LIM = 16'd20000;
  localparam logic [15:0] RST_CHARGE_LIM    = 16'd5000;

  // margin above the cell minimum used as a drain target
  localparam logic [16:0] SAFE_MARGIN_MV = 17'd50;

  typedef struct packed {
    logic [17:0] pack_max_mv;
    logic [17:0] pack_min_mv;
    logic [15:0] cell_max_mv;
    logic [15:0] cell_min_mv;
    logic [15:0] imbalance_mv;
    logic [15:0] upper_safe_mv;
    logic [15:0] discharge_limit_ma;
    logic [15:0] charge_limit_ma;
  } cfg_t;

  typedef struct packed {
    logic [15:0] cell_a_mv;
    logic [15:0] cell_b_mv;
    logic [15:0] cell_c_mv;
    logic [15:0] pack_current_ma;
    logic        charging;
  } in_t;

  typedef struct packed {
    logic [17:0] pack_mv;
    logic [15:0] lowest_cell_mv;
    logic        over_current;
    logic        pack_full;
    logic        pack_dead;
    logic [2:0]  overvolt_mask;
    logic [15:0] overvolt_target_mv;
    logic [2:0]  balance_mask;
    logic [15:0] balance_target_mv;
    logic [2:0]  undervolt_mask;
  } out_t;

  // after sum / minimum / per-cell limit compares
  typedef struct packed {
    logic [2:0][15:0] cells;
    logic [17:0]      pack_mv;
    logic [15:0]      min_mv;
    logic             chg;
    logic             oc;
    logic [2:0]       ov;
    logic [2:0]       uv;
  } s1_t;

  // after pack flags, thresholds and overvoltage target
  typedef struct packed {
    logic [2:0][15:0] cells;
    logic [17:0]      pack_mv;
    logic [15:0]      min_mv;
    logic             chg;
    logic             oc;
    logic             full;
    logic             dead;
    logic [2:0]       ov;
    logic [2:0]       uv;
    logic [15:0]      ov_tgt;
    logic [16:0]      bal_thr;
    logic             in_window;
    logic             below_min;
    logic [2:0]       safe_ge;
    logic [15:0]      safe_sat;
  } s2_t;

endpackage

// ----- hdl/tcbp_cfg.sv -----
// ----------------------------------------------------------------------------
// tcbp_cfg
// Configuration register file, written through a plain write port.
// ----------------------------------------------------------------------------
module tcbp_cfg (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [tcbp_pkg::CFG_IDX_W-1:0]   cfg_idx,
  input  logic [tcbp_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  output tcbp_pkg::cfg_t                   cfg
);
  import tcbp_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_idx)
        REG_PACK_MAX:      cfg_nxt.pack_max_mv        = cfg_wdata;
        REG_PACK_MIN:      cfg_nxt.pack_min_mv        = cfg_wdata;
        REG_CELL_MAX:      cfg_nxt.cell_max_mv        = cfg_wdata[15:0];
        REG_CELL_MIN:      cfg_nxt.cell_min_mv        = cfg_wdata[15:0];
        REG_IMBALANCE:     cfg_nxt.imbalance_mv       = cfg_wdata[15:0];
        REG_UPPER_SAFE:    cfg_nxt.upper_safe_mv      = cfg_wdata[15:0];
        REG_DISCHARGE_LIM: cfg_nxt.discharge_limit_ma = cfg_wdata[15:0];
        REG_CHARGE_LIM:    cfg_nxt.charge_limit_ma    = cfg_wdata[15:0];
        default:           cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.pack_max_mv        <= RST_PACK_MAX;
      cfg_r.pack_min_mv        <= RST_PACK_MIN;
      cfg_r.cell_max_mv        <= RST_CELL_MAX;
      cfg_r.cell_min_mv        <= RST_CELL_MIN;
      cfg_r.imbalance_mv       <= RST_IMBALANCE;
      cfg_r.upper_safe_mv      <= RST_UPPER_SAFE;
      cfg_r.discharge_limit_ma <= RST_DISCHARGE_LIM;
      cfg_r.charge_limit_ma    <= RST_CHARGE_LIM;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// ----- hdl/tcbp_front.sv -----
// ----------------------------------------------------------------------------
// tcbp_front
// Stage 1: pack sum, smallest cell, per-cell limit and overcurrent compares.
// ----------------------------------------------------------------------------
module tcbp_front (
  input  logic           clk,
  input  logic           rst_n,
  input  tcbp_pkg::cfg_t cfg,
  input  logic           vld_i,
  input  tcbp_pkg::in_t  data_i,
  output logic           rdy_o,
  output logic           vld_o,
  output tcbp_pkg::s1_t  data_o,
  input  logic           rdy_i
);
  import tcbp_pkg::*;

  logic             vld_r;
  s1_t              data_r;
  s1_t              data_nxt;
  logic [2:0][15:0] cells;
  logic [15:0]      min_ab;
  logic [15:0]      cur_lim;

  assign cells = {data_i.cell_c_mv, data_i.cell_b_mv, data_i.cell_a_mv};
  assign min_ab  = (cells[1] < cells[0]) ? cells[1] : cells[0];
  assign cur_lim = data_i.charging ? cfg.charge_limit_ma : cfg.discharge_limit_ma;

  always_comb begin
    data_nxt.cells   = cells;
    data_nxt.pack_mv = {2'b00, cells[0]} + {2'b00, cells[1]} + {2'b00, cells[2]};
    data_nxt.min_mv  = (cells[2] < min_ab) ? cells[2] : min_ab;
    data_nxt.chg     = data_i.charging;
    data_nxt.oc      = (data_i.pack_current_ma >= cur_lim);
    for (int i = 0; i < 3; i++) begin
      data_nxt.uv[i] = (cells[i] <= cfg.cell_min_mv);
      data_nxt.ov[i] = data_i.charging && (cells[i] >= cfg.cell_max_mv);
    end
  end

  assign rdy_o = !vld_r || rdy_i;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (rdy_o) begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_o && vld_i) begin
      data_r <= data_nxt;
    end
  end

  assign vld_o  = vld_r;
  assign data_o = data_r;

endmodule

// ----- hdl/tcbp_mid.sv -----
// ----------------------------------------------------------------------------
// tcbp_mid
// Stage 2: pack flags, balance threshold, safe level and overvoltage target.
// ----------------------------------------------------------------------------
module tcbp_mid (
  input  logic           clk,
  input  logic           rst_n,
  input  tcbp_pkg::cfg_t cfg,
  input  logic           vld_i,
  input  tcbp_pkg::s1_t  data_i,
  output logic           rdy_o,
  output logic           vld_o,
  output tcbp_pkg::s2_t  data_o,
  input  logic           rdy_i
);
  import tcbp_pkg::*;

  logic        vld_r;
  s2_t         data_r;
  s2_t         data_nxt;
  logic [16:0] safe_mv;
  logic [15:0] safe_sat;

  // unsaturated safe level for compares, saturated copy for targets
  assign safe_mv  = {1'b0, cfg.cell_min_mv} + SAFE_MARGIN_MV;
  assign safe_sat = safe_mv[16] ? 16'hFFFF : safe_mv[15:0];

  always_comb begin
    data_nxt.cells     = data_i.cells;
    data_nxt.pack_mv   = data_i.pack_mv;
    data_nxt.min_mv    = data_i.min_mv;
    data_nxt.chg       = data_i.chg;
    data_nxt.oc        = data_i.oc;
    data_nxt.ov        = data_i.ov;
    data_nxt.uv        = data_i.uv;
    data_nxt.full      = data_i.chg && (data_i.pack_mv >= cfg.pack_max_mv);
    data_nxt.dead      = (data_i.pack_mv <= cfg.pack_min_mv);
    data_nxt.bal_thr   = {1'b0, data_i.min_mv} + {1'b0, cfg.imbalance_mv};
    data_nxt.in_window = (data_i.min_mv > cfg.cell_min_mv) &&
                         (data_i.min_mv < cfg.cell_max_mv);
    data_nxt.below_min = (data_i.min_mv <= cfg.cell_min_mv);
    data_nxt.safe_sat  = safe_sat;
    for (int i = 0; i < 3; i++) begin
      data_nxt.safe_ge[i] = ({1'b0, data_i.cells[i]} >= safe_mv);
    end
    priority if (data_i.ov == 3'b000) begin
      data_nxt.ov_tgt = '0;
    end else if (data_i.min_mv < cfg.cell_min_mv) begin
      data_nxt.ov_tgt = safe_sat;
    end else if (data_i.min_mv > cfg.cell_max_mv) begin
      data_nxt.ov_tgt = cfg.upper_safe_mv;
    end else begin
      data_nxt.ov_tgt = data_i.min_mv;
    end
  end

  assign rdy_o = !vld_r || rdy_i;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (rdy_o) begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_o && vld_i) begin
      data_r <= data_nxt;
    end
  end

  assign vld_o  = vld_r;
  assign data_o = data_r;

endmodule

// ----- hdl/tcbp_back.sv -----
// ----------------------------------------------------------------------------
// tcbp_back
// Stage 3: balance compares, balance mask and target, output register.
// ----------------------------------------------------------------------------
module tcbp_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           vld_i,
  input  tcbp_pkg::s2_t  data_i,
  output logic           rdy_o,
  output logic           vld_o,
  output tcbp_pkg::out_t data_o,
  input  logic           rdy_i
);
  import tcbp_pkg::*;

  logic       vld_r;
  out_t       data_r;
  out_t       data_nxt;
  logic [2:0] bal;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      bal[i] = data_i.chg && ({1'b0, data_i.cells[i]} >= data_i.bal_thr) &&
               (data_i.in_window || (data_i.below_min && data_i.safe_ge[i]));
    end
  end

  always_comb begin
    data_nxt.pack_mv            = data_i.pack_mv;
    data_nxt.lowest_cell_mv     = data_i.min_mv;
    data_nxt.over_current       = data_i.oc;
    data_nxt.pack_full          = data_i.full;
    data_nxt.pack_dead          = data_i.dead;
    data_nxt.overvolt_mask      = data_i.ov;
    data_nxt.overvolt_target_mv = data_i.ov_tgt;
    data_nxt.balance_mask       = bal;
    data_nxt.undervolt_mask     = data_i.uv;
    // window and below-minimum cases exclude each other
    priority if (bal == 3'b000) begin
      data_nxt.balance_target_mv = '0;
    end else if (data_i.in_window) begin
      data_nxt.balance_target_mv = data_i.min_mv;
    end else begin
      data_nxt.balance_target_mv = data_i.safe_sat;
    end
  end

  assign rdy_o = !vld_r || rdy_i;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (rdy_o) begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_o && vld_i) begin
      data_r <= data_nxt;
    end
  end

  assign vld_o  = vld_r;
  assign data_o = data_r;

endmodule

// ----- hdl/three_cell_battery_protection_check.sv -----
// stages: three register stages, front, mid and back; out_valid rises once
// an input transfer has passed all three, and the result transfers unless stalled
// throughput: one item per cycle; each stage holds its item while the stage
// after it is full and stalled
// reset: synchronous active-low rst_n clears all stage valid bits and
// loads the default thresholds into the configuration registers
// ----------------------------------------------------------------------------
// three_cell_battery_protection_check
// Pipelined cell protection, pack status and drain mask evaluation.
// ----------------------------------------------------------------------------
module three_cell_battery_protection_check (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [tcbp_pkg::CFG_IDX_W-1:0]   cfg_idx,
  input  logic [tcbp_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  tcbp_pkg::in_t                    in_data,
  output logic                             out_valid,
  input  logic                             out_stall,
  output tcbp_pkg::out_t                   out_data
);
  import tcbp_pkg::*;

  cfg_t cfg;
  logic s1_vld;
  logic s2_vld;
  logic s1_rdy;
  logic s2_rdy;
  logic s3_rdy;
  s1_t  s1_data;
  s2_t  s2_data;

  tcbp_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  tcbp_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg    (cfg),
    .vld_i  (in_valid),
    .data_i (in_data),
    .rdy_o  (s1_rdy),
    .vld_o  (s1_vld),
    .data_o (s1_data),
    .rdy_i  (s2_rdy)
  );

  tcbp_mid u_mid (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg    (cfg),
    .vld_i  (s1_vld),
    .data_i (s1_data),
    .rdy_o  (s2_rdy),
    .vld_o  (s2_vld),
    .data_o (s2_data),
    .rdy_i  (s3_rdy)
  );

  tcbp_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .vld_i  (s2_vld),
    .data_i (s2_data),
    .rdy_o  (s3_rdy),
    .vld_o  (out_valid),
    .data_o (out_data),
    .rdy_i  (!out_stall)
  );

  assign in_stall = !s1_rdy;

endmodule

// ----- hdl/tcbp_checker.sv -----
`include "assert_macros.svh"
// ----------------------------------------------------------------------------
// tcbp_checker
// Port-level checks on the protection check pipeline, bound to the top level.
// ----------------------------------------------------------------------------
module tcbp_checker (
  input logic           clk,
  input logic           rst_n,
  input logic           in_valid,
  input logic           in_stall,
  input tcbp_pkg::in_t  in_data,
  input logic           out_valid,
  input logic           out_stall,
  input tcbp_pkg::out_t out_data
);
  import tcbp_pkg::*;

  // a stalled result stays offered and unchanged
  `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_data))

  // with the output side open every stage can advance, so input is taken
  `ASSERT_IMPLY(a_no_stall_when_open, clk, rst_n, !out_stall, !in_stall)

  // a drain target is only given together with a nonempty mask
  `ASSERT_IMPLY(a_ov_target_zero, clk, rst_n,
                out_valid && (out_data.overvolt_mask == 3'b000),
                out_data.overvolt_target_mv == 16'd0)

  `ASSERT_IMPLY(a_bal_target_zero, clk, rst_n,
                out_valid && (out_data.balance_mask == 3'b000),
                out_data.balance_target_mv == 16'd0)

  // a stalled input stays offered and unchanged
  `ASSERT_NEXT(a_in_hold, clk, rst_n, in_valid && in_stall, in_valid && $stable(in_data))

endmodule

bind three_cell_battery_protection_check tcbp_checker u_tcbp_checker (.*);

// ----- dv/three_cell_battery_protection_check_tb.sv -----
// ----------------------------------------------------------------------------
// three_cell_battery_protection_check_tb
// Drives cell voltage, pack current and mode samples through the protection
// pipeline and compares every result, field by field, against an in-bench
// predictor or fixed values. A short directed script covers the limits and
// corner cases; the rest is random samples under several threshold settings,
// with random sender bursts, receiver stalls and long receiver hold-offs.
// ----------------------------------------------------------------------------
module three_cell_battery_protection_check_tb;
  import tcbp_pkg::*;

  localparam int ITEMS_PER_PHASE = 155;
  localparam int NUM_PHASES      = 7;
  localparam int BACKLOG_CYCLES  = 60;
  localparam int DRAIN_MARGIN_MV = 50;

  typedef enum logic {ROW_SAMPLE, ROW_WRITE} row_kind_t;
  typedef enum {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_EVERY_THIRD} stall_mode_t;

  typedef struct {
    row_kind_t             kind;
    in_t                   sample;
    bit                    known;
    out_t                  want;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] value;
  } script_row_t;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  logic                  in_valid;
  logic                  in_stall;
  in_t                   in_data;
  logic                  out_valid;
  logic                  out_stall;
  out_t                  out_data;

  cfg_t        thr;
  out_t        pending_status[$];
  script_row_t script[$];
  int          fails = 0;
  int          burst_left = 1;
  int          backlog_reqs = 0;
  int          backlog_served = 0;

  three_cell_battery_protection_check DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always #10 clk = ~clk;

  function automatic logic [15:0] clamp16(int v);
    if (v < 0) return 16'd0;
    if (v > 65535) return 16'hFFFF;
    return v[15:0];
  endfunction

  function automatic void default_thresholds();
    thr.pack_max_mv        = 18'd7400;
    thr.pack_min_mv        = 18'd1000;
    thr.cell_max_mv        = 16'd2600;
    thr.cell_min_mv        = 16'd1000;
    thr.imbalance_mv       = 16'd300;
    thr.upper_safe_mv      = 16'd2450;
    thr.discharge_limit_ma = 16'd20000;
    thr.charge_limit_ma    = 16'd5000;
  endfunction

  // expected status for one sample under the current thresholds
  function automatic out_t protection_status(in_t s);
    out_t        r;
    logic [15:0] cell_mv [3];
    logic [15:0] mn;
    logic [15:0] limit;
    logic [15:0] safe_sat;
    logic [16:0] safe;
    logic [16:0] bal_thr;
    r = '0;
    cell_mv[0] = s.cell_a_mv;
    cell_mv[1] = s.cell_b_mv;
    cell_mv[2] = s.cell_c_mv;
    mn = cell_mv[0];
    if (cell_mv[1] < mn) mn = cell_mv[1];
    if (cell_mv[2] < mn) mn = cell_mv[2];
    // comparisons use the 17-bit sums, targets the saturated value
    safe     = {1'b0, thr.cell_min_mv} + 17'(DRAIN_MARGIN_MV);
    safe_sat = safe[16] ? 16'hFFFF : safe[15:0];
    bal_thr  = {1'b0, mn} + {1'b0, thr.imbalance_mv};
    r.pack_mv        = {2'b0, cell_mv[0]} + {2'b0, cell_mv[1]} + {2'b0, cell_mv[2]};
    r.lowest_cell_mv = mn;
    limit            = s.charging ? thr.charge_limit_ma : thr.discharge_limit_ma;
    r.over_current   = s.pack_current_ma >= limit;
    r.pack_full      = s.charging && (r.pack_mv >= thr.pack_max_mv);
    r.pack_dead      = r.pack_mv <= thr.pack_min_mv;
    for (int i = 0; i < 3; i++) begin
      r.undervolt_mask[i] = cell_mv[i] <= thr.cell_min_mv;
      if (s.charging) begin
        r.overvolt_mask[i] = cell_mv[i] >= thr.cell_max_mv;
        if ({1'b0, cell_mv[i]} >= bal_thr) begin
          if (mn > thr.cell_min_mv && mn < thr.cell_max_mv) begin
            r.balance_mask[i]   = 1'b1;
            r.balance_target_mv = mn;
          end else if (mn <= thr.cell_min_mv && {1'b0, cell_mv[i]} >= safe) begin
            r.balance_mask[i]   = 1'b1;
            r.balance_target_mv = safe_sat;
          end
        end
      end
    end
    if (r.overvolt_mask != 3'b000) begin
      if (mn < thr.cell_min_mv) r.overvolt_target_mv = safe_sat;
      else if (mn > thr.cell_max_mv) r.overvolt_target_mv = thr.upper_safe_mv;
      else r.overvolt_target_mv = mn;
    end
    return r;
  endfunction

  function automatic void flag_field(string name, logic [17:0] want, logic [17:0] got);
    if (got !== want) begin
      $error("%s expected %0d got %0d", name, want, got);
      fails++;
    end
  endfunction

  function automatic void check_status(out_t got, out_t want);
    flag_field("pack_mv", want.pack_mv, got.pack_mv);
    flag_field("lowest_cell_mv", 18'(want.lowest_cell_mv), 18'(got.lowest_cell_mv));
    flag_field("over_current", 18'(want.over_current), 18'(got.over_current));
    flag_field("pack_full", 18'(want.pack_full), 18'(got.pack_full));
    flag_field("pack_dead", 18'(want.pack_dead), 18'(got.pack_dead));
    flag_field("overvolt_mask", 18'(want.overvolt_mask), 18'(got.overvolt_mask));
    flag_field("overvolt_target_mv", 18'(want.overvolt_target_mv),
               18'(got.overvolt_target_mv));
    flag_field("balance_mask", 18'(want.balance_mask), 18'(got.balance_mask));
    flag_field("balance_target_mv", 18'(want.balance_target_mv),
               18'(got.balance_target_mv));
    flag_field("undervolt_mask", 18'(want.undervolt_mask), 18'(got.undervolt_mask));
  endfunction

  function automatic in_t make_sample(logic [15:0] a, logic [15:0] b, logic [15:0] c,
                                      logic [15:0] cur, logic chg);
    in_t s;
    s.cell_a_mv       = a;
    s.cell_b_mv       = b;
    s.cell_c_mv       = c;
    s.pack_current_ma = cur;
    s.charging        = chg;
    return s;
  endfunction

  function automatic void add_sample(logic [15:0] a, logic [15:0] b, logic [15:0] c,
                                     logic [15:0] cur, logic chg);
    script_row_t row;
    row        = '{kind: ROW_SAMPLE, default: '0};
    row.sample = make_sample(a, b, c, cur, chg);
    script.push_back(row);
  endfunction

  function automatic void add_known(logic [15:0] a, logic [15:0] b, logic [15:0] c,
                                    logic [15:0] cur, logic chg, out_t want);
    script_row_t row;
    row        = '{kind: ROW_SAMPLE, default: '0};
    row.sample = make_sample(a, b, c, cur, chg);
    row.known  = 1'b1;
    row.want   = want;
    script.push_back(row);
  endfunction

  function automatic void add_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
    script_row_t row;
    row       = '{kind: ROW_WRITE, default: '0};
    row.idx   = idx;
    row.value = value;
    script.push_back(row);
  endfunction

  // a cell level near one of the active thresholds, an extreme, or anything
  function automatic logic [15:0] pick_level();
    int base;
    int d;
    d = $urandom_range(0, 8);
    case ($urandom_range(0, 7))
      0: base = int'(thr.cell_min_mv);
      1: base = int'(thr.cell_max_mv);
      2: base = int'(thr.cell_min_mv) + DRAIN_MARGIN_MV;
      3: base = int'(thr.upper_safe_mv);
      4: return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
      default: return 16'($urandom());
    endcase
    return clamp16(base + d - 4);
  endfunction

  function automatic in_t random_sample();
    in_t         s;
    logic [15:0] cell_mv [3];
    logic [15:0] mn_base;
    int          d;
    int          target;
    mn_base = pick_level();
    for (int i = 0; i < 3; i++) begin
      d = $urandom_range(0, 4);
      case ($urandom_range(0, 2))
        0: cell_mv[i] = pick_level();
        1: cell_mv[i] = clamp16(int'(mn_base) + int'(thr.imbalance_mv) + d - 2);
        default: cell_mv[i] = mn_base;
      endcase
    end
    s.charging = $urandom_range(0, 9) < 7;
    // aim the pack sum at one of the pack limits now and then
    if ($urandom_range(0, 7) == 0) begin
      d = $urandom_range(0, 2);
      target = ($urandom_range(0, 1) ? int'(thr.pack_max_mv) : int'(thr.pack_min_mv)) + d - 1;
      if (target < 0) target = 0;
      cell_mv[0] = clamp16(target / 3);
      cell_mv[1] = clamp16(target / 3);
      cell_mv[2] = clamp16(target - 2 * (target / 3));
    end
    s.cell_a_mv = cell_mv[0];
    s.cell_b_mv = cell_mv[1];
    s.cell_c_mv = cell_mv[2];
    if ($urandom_range(0, 1)) begin
      d = $urandom_range(0, 2);
      s.pack_current_ma = clamp16((s.charging ? int'(thr.charge_limit_ma)
                                              : int'(thr.discharge_limit_ma)) + d - 1);
    end else begin
      s.pack_current_ma = 16'($urandom());
    end
    return s;
  endfunction

  // hold the sample until it transfers, then idle between bursts
  task automatic offer_sample(in_t s, bit known, out_t want);
    int gap;
    in_valid <= 1'b1;
    in_data  <= s;
    do @(posedge clk); while (in_stall);
    pending_status.push_back(known ? want : protection_status(s));
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = ($urandom_range(0, 9) == 0) ? 48 : $urandom_range(1, 10);
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (pending_status.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // leaves cfg_we high; the caller lowers it after the last write
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    case (idx)
      REG_PACK_MAX:      thr.pack_max_mv        = value;
      REG_PACK_MIN:      thr.pack_min_mv        = value;
      REG_CELL_MAX:      thr.cell_max_mv        = value[15:0];
      REG_CELL_MIN:      thr.cell_min_mv        = value[15:0];
      REG_IMBALANCE:     thr.imbalance_mv       = value[15:0];
      REG_UPPER_SAFE:    thr.upper_safe_mv      = value[15:0];
      REG_DISCHARGE_LIM: thr.discharge_limit_ma = value[15:0];
      REG_CHARGE_LIM:    thr.charge_limit_ma    = value[15:0];
      default: ;
    endcase
  endtask

  // junk in the upper data bits of the 16-bit registers must be dropped
  task automatic load_thresholds(cfg_t s);
    write_reg(REG_PACK_MAX, s.pack_max_mv);
    write_reg(REG_PACK_MIN, s.pack_min_mv);
    write_reg(REG_CELL_MAX, {2'($urandom()), s.cell_max_mv});
    write_reg(REG_CELL_MIN, {2'($urandom()), s.cell_min_mv});
    write_reg(REG_IMBALANCE, {2'($urandom()), s.imbalance_mv});
    write_reg(REG_UPPER_SAFE, {2'($urandom()), s.upper_safe_mv});
    write_reg(REG_DISCHARGE_LIM, {2'($urandom()), s.discharge_limit_ma});
    write_reg(REG_CHARGE_LIM, {2'($urandom()), s.charge_limit_ma});
    cfg_we <= 1'b0;
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_status.size() == 0) begin
        $error("result transfer with no sample outstanding");
        fails++;
      end else begin
        check_status(out_data, pending_status.pop_front());
      end
    end
  end

  initial begin : receiver
    stall_mode_t mode;
    int          left;
    out_stall = 1'b0;
    mode      = STALL_NONE;
    left      = 0;
    forever begin
      @(posedge clk);
      if (backlog_reqs != backlog_served) begin
        // long hold-off so the pipeline fills and in_stall rises
        out_stall <= 1'b1;
        repeat (BACKLOG_CYCLES) @(posedge clk);
        backlog_served++;
      end
      if (left == 0) begin
        mode = stall_mode_t'($urandom_range(0, 3));
        left = $urandom_range(4, 64);
      end
      left--;
      case (mode)
        STALL_NONE:        out_stall <= 1'b0;
        STALL_LIGHT:       out_stall <= $urandom_range(0, 99) < 30;
        STALL_HEAVY:       out_stall <= $urandom_range(0, 99) < 80;
        STALL_EVERY_THIRD: out_stall <= (left % 3) == 0;
        default:           out_stall <= 1'b0;
      endcase
    end
  end

  initial begin : watchdog
    #4000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin : stimulus
    cfg_t s;
    int   waited;
    rst_n     = 1'b0;
    cfg_we    = 1'b0;
    cfg_idx   = REG_PACK_MAX;
    cfg_wdata = '0;
    in_valid  = 1'b0;
    in_data   = '0;
    default_thresholds();

    // result field order: pack, lowest, oc, full, dead, ov mask, ov target,
    // balance mask, balance target, uv mask
    add_known(16'd0, 16'd0, 16'd0, 16'd0, 1'b0,
              '{18'd0, 16'd0, 1'b0, 1'b0, 1'b1, 3'b000, 16'd0, 3'b000, 16'd0, 3'b111});
    add_known(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1,
              '{18'd196605, 16'hFFFF, 1'b1, 1'b1, 1'b0, 3'b111, 16'd2450, 3'b000, 16'd0,
                3'b000});
    add_known(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0,
              '{18'd196605, 16'hFFFF, 1'b1, 1'b0, 1'b0, 3'b000, 16'd0, 3'b000, 16'd0,
                3'b000});
    add_sample(16'd2000, 16'd2300, 16'd2299, 16'd4999, 1'b1);   // imbalance exactly
    add_sample(16'd2600, 16'd2000, 16'd2100, 16'd5000, 1'b1);   // cell and current at limit
    add_sample(16'd2599, 16'd2601, 16'd2000, 16'd0, 1'b1);
    add_sample(16'd1000, 16'd1050, 16'd1049, 16'd0, 1'b1);      // low cell, safe level edge
    add_sample(16'd999, 16'd2700, 16'd1500, 16'hFFFF, 1'b1);
    add_sample(16'd2700, 16'd2800, 16'd2650, 16'd0, 1'b1);      // all above cell max
    add_sample(16'd2467, 16'd2467, 16'd2466, 16'd0, 1'b1);      // pack exactly full
    add_sample(16'd2466, 16'd2467, 16'd2466, 16'd0, 1'b1);
    add_sample(16'd334, 16'd333, 16'd333, 16'd0, 1'b0);         // pack exactly dead
    add_sample(16'd334, 16'd334, 16'd333, 16'd0, 1'b0);
    add_sample(16'd2700, 16'd2000, 16'd2100, 16'd20000, 1'b0);  // no drain in discharge
    add_sample(16'd2000, 16'd2000, 16'd2000, 16'd19999, 1'b0);
    add_sample(16'd2300, 16'd2000, 16'd2400, 16'd0, 1'b1);
    add_sample(16'd2400, 16'd2300, 16'd2000, 16'd0, 1'b1);
    add_write(REG_IMBALANCE, 18'd65535);
    add_sample(16'd0, 16'hFFFF, 16'd1000, 16'd0, 1'b1);
    add_sample(16'd5, 16'hFFFF, 16'd6, 16'd0, 1'b1);            // threshold past 16 bits
    // inverted cell limits with a safe level that saturates
    add_write(REG_CELL_MAX, 18'd1000);
    add_write(REG_CELL_MIN, 18'd65500);
    add_sample(16'd2000, 16'd2000, 16'd2000, 16'd0, 1'b1);
    add_sample(16'd1000, 16'd3000, 16'hFFFF, 16'd0, 1'b0);
    add_write(REG_IMBALANCE, 18'd0);
    add_write(REG_CELL_MIN, 18'd65485);
    add_sample(16'hFFFF, 16'hFFFF, 16'd65000, 16'd0, 1'b1);
    add_sample(16'hFFFF, 16'd65000, 16'hFFFF, 16'd0, 1'b1);

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    foreach (script[i]) begin
      if (script[i].kind == ROW_WRITE) begin
        settle();
        write_reg(script[i].idx, script[i].value);
        cfg_we <= 1'b0;
      end else begin
        offer_sample(script[i].sample, script[i].known, script[i].want);
      end
    end

    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0: s = '{18'd7400, 18'd1000, 16'd2600, 16'd1000, 16'd300, 16'd2450, 16'd20000,
                 16'd5000};
        2: s = '0;
        3: s = '{18'd196605, 18'd196605, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                 16'hFFFF};
        4: s = '{18'd3000, 18'd6000, 16'd1200, 16'd65500, 16'd10, 16'hFFFF, 16'd1,
                 16'hFFFF};
        5: begin
          s = '{18'd7400, 18'd1000, 16'd0, 16'd0, 16'd0, 16'd2450, 16'd20000, 16'd5000};
          s.cell_max_mv = 16'($urandom_range(500, 4000));
          s.cell_min_mv = s.cell_max_mv;
        end
        default: begin
          s.pack_max_mv        = 18'($urandom_range(0, 196605));
          s.pack_min_mv        = 18'($urandom_range(0, 196605));
          s.cell_max_mv        = 16'($urandom());
          s.cell_min_mv        = 16'($urandom());
          s.imbalance_mv       = 16'($urandom_range(0, 1000));
          s.upper_safe_mv      = 16'($urandom());
          s.discharge_limit_ma = 16'($urandom());
          s.charge_limit_ma    = 16'($urandom());
        end
      endcase
      settle();
      load_thresholds(s);
      if (p % 2 == 1) backlog_reqs <= backlog_reqs + 1;
      repeat (ITEMS_PER_PHASE) offer_sample(random_sample(), 1'b0, '0);
    end

    in_valid <= 1'b0;
    waited = 0;
    while (pending_status.size() != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    if (pending_status.size() != 0) begin
      $error("%0d results never arrived", pending_status.size());
      fails++;
    end
    repeat (8) @(posedge clk);
    if (fails == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
